/* rtl/assert_macros.svh */
// Assertion helpers used by the selector back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSEL_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsel assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TSEL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsel assertion failed");

`endif

/* rtl/tsel_pkg.sv */
package tsel_pkg;

   localparam int SCORE_W = 16;
   localparam int INDEX_W = 10;
   localparam int PROB_W  = 16;
   localparam int SUM_W   = 27;
   localparam int EXP_W   = 17;
   localparam int TOP_W   = 4;
   localparam logic [SUM_W-1:0]  SUM_LIMIT = {SUM_W{1'b1}};
   localparam logic [PROB_W-1:0] PROB_MAX  = {PROB_W{1'b1}};
   localparam logic [15:0]       EXP_RANGE = 16'd4096;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SUM,
      B_DRAIN,
      B_EXP,
      B_DIV,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] max_score;
      logic                      overflow;
   } job_info_type;

   // e^-i at scale 65536; entries past eleven are zero.
   function automatic logic [EXP_W-1:0] e_int(input logic [4:0] i);
      logic [EXP_W-1:0] r;
      case (i)
         5'd0:    r = 17'd65536;
         5'd1:    r = 17'd24109;
         5'd2:    r = 17'd8869;
         5'd3:    r = 17'd3263;
         5'd4:    r = 17'd1200;
         5'd5:    r = 17'd442;
         5'd6:    r = 17'd162;
         5'd7:    r = 17'd60;
         5'd8:    r = 17'd22;
         5'd9:    r = 17'd8;
         5'd10:   r = 17'd3;
         5'd11:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // e^(-a/16) at scale 65536.
   function automatic logic [EXP_W-1:0] e_hi(input logic [3:0] a);
      logic [EXP_W-1:0] r;
      case (a)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd61565;
         4'd2:    r = 17'd57835;
         4'd3:    r = 17'd54331;
         4'd4:    r = 17'd51039;
         4'd5:    r = 17'd47947;
         4'd6:    r = 17'd45042;
         4'd7:    r = 17'd42313;
         4'd8:    r = 17'd39750;
         4'd9:    r = 17'd37341;
         4'd10:   r = 17'd35079;
         4'd11:   r = 17'd32954;
         4'd12:   r = 17'd30957;
         4'd13:   r = 17'd29081;
         4'd14:   r = 17'd27319;
         default: r = 17'd25664;
      endcase
      return r;
   endfunction

   // e^(-b/256) at scale 65536.
   function automatic logic [EXP_W-1:0] e_lo(input logic [3:0] b);
      logic [EXP_W-1:0] r;
      case (b)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd65280;
         4'd2:    r = 17'd65026;
         4'd3:    r = 17'd64772;
         4'd4:    r = 17'd64520;
         4'd5:    r = 17'd64268;
         4'd6:    r = 17'd64018;
         4'd7:    r = 17'd63768;
         4'd8:    r = 17'd63520;
         4'd9:    r = 17'd63272;
         4'd10:   r = 17'd63025;
         4'd11:   r = 17'd62780;
         4'd12:   r = 17'd62535;
         4'd13:   r = 17'd62291;
         4'd14:   r = 17'd62049;
         default: r = 17'd61806;
      endcase
      return r;
   endfunction

endpackage

/* rtl/topk_softmax_selector_unit.sv */
// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_stall  req_score, req_last_score
// rsp_       out        rsp_valid/rsp_stall  rsp_class_index, rsp_class_score,
//                                            rsp_probability, rsp_overflow,
//                                            rsp_last_result
// csr_       in         csr_write_enable     csr_write_data (top_count)
//
// Scores load one per cycle into the score memory while the ranking updates,
// except while the request side stalls: after the last score it stalls while the
// memory is read once per score through the three-stage exponent pipeline.
// Each result then passes through an exponent step, a divider step and an output
// step; the next vector may load while results are still being produced.
// Reset is synchronous, active high, and needs no clearing pass.
// A stalled result holds in the output register; the back end waits on it.
module topk_softmax_selector_unit #(
   parameter int MAX_SCORES = 1024,
   parameter int MAX_TOP    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tsel_pkg::SCORE_W-1:0]  req_score,
   input  logic                                 req_last_score,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tsel_pkg::INDEX_W-1:0]         rsp_class_index,
   output logic signed [tsel_pkg::SCORE_W-1:0]  rsp_class_score,
   output logic [tsel_pkg::PROB_W-1:0]          rsp_probability,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last_result,
   input  logic                                 csr_write_enable,
   input  logic [tsel_pkg::TOP_W-1:0]           csr_write_data
);
   import tsel_pkg::*;

   localparam int AW = $clog2(MAX_SCORES);
   localparam int CW = $clog2(MAX_SCORES + 1);
   localparam int KW = $clog2(MAX_TOP + 1);

   logic [TOP_W-1:0]          top_count_ff;
   logic                      job_valid;
   logic                      job_take;
   job_info_type              job_info;
   logic [CW-1:0]             job_count;
   logic [KW-1:0]             job_k;
   logic signed [SCORE_W-1:0] job_scores [MAX_TOP];
   logic [AW-1:0]             job_indices [MAX_TOP];
   logic                      store_busy;
   logic [AW-1:0]             rd_addr;
   logic signed [SCORE_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TOP_W'(5);
      end else if (csr_write_enable) begin
         top_count_ff <= csr_write_data;
      end
   end

   tsel_front #(
      .MAX_SCORES (MAX_SCORES),
      .MAX_TOP    (MAX_TOP)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_score      (req_score),
      .req_last_score (req_last_score),
      .top_count      (top_count_ff),
      .job_valid      (job_valid),
      .job_take       (job_take),
      .job_info       (job_info),
      .job_count      (job_count),
      .job_k          (job_k),
      .job_scores     (job_scores),
      .job_indices    (job_indices),
      .store_busy     (store_busy),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   tsel_back #(
      .MAX_SCORES (MAX_SCORES),
      .MAX_TOP    (MAX_TOP)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job_take        (job_take),
      .job_info        (job_info),
      .job_count       (job_count),
      .job_k           (job_k),
      .job_scores      (job_scores),
      .job_indices     (job_indices),
      .store_busy      (store_busy),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_class_index (rsp_class_index),
      .rsp_class_score (rsp_class_score),
      .rsp_probability (rsp_probability),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result)
   );

endmodule

/* rtl/tsel_front.sv */
module tsel_front #(
   parameter int MAX_SCORES = 1024,
   parameter int MAX_TOP    = 8,
   parameter int AW         = $clog2(MAX_SCORES),
   parameter int CW         = $clog2(MAX_SCORES + 1),
   parameter int KW         = $clog2(MAX_TOP + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tsel_pkg::SCORE_W-1:0]  req_score,
   input  logic                                 req_last_score,
   input  logic [tsel_pkg::TOP_W-1:0]           top_count,
   output logic                                 job_valid,
   input  logic                                 job_take,
   output tsel_pkg::job_info_type               job_info,
   output logic [CW-1:0]                        job_count,
   output logic [KW-1:0]                        job_k,
   output logic signed [tsel_pkg::SCORE_W-1:0]  job_scores [MAX_TOP],
   output logic [AW-1:0]                        job_indices [MAX_TOP],
   input  logic                                 store_busy,
   input  logic [AW-1:0]                        rd_addr,
   output logic signed [tsel_pkg::SCORE_W-1:0]  rd_data
);
   import tsel_pkg::*;

   logic signed [SCORE_W-1:0] store_mem [MAX_SCORES];
   logic signed [SCORE_W-1:0] rd_data_ff;

   logic [CW-1:0]             count_ff;
   logic signed [SCORE_W-1:0] max_ff;
   logic                      ovf_ff;
   logic signed [SCORE_W-1:0] bs_ff [MAX_TOP];
   logic [AW-1:0]             bi_ff [MAX_TOP];
   logic [MAX_TOP-1:0]        bv_ff;

   logic                      job_valid_ff;
   job_info_type              job_info_ff;
   logic [CW-1:0]             job_count_ff;
   logic [KW-1:0]             job_k_ff;
   logic signed [SCORE_W-1:0] job_scores_ff [MAX_TOP];
   logic [AW-1:0]             job_indices_ff [MAX_TOP];

   logic                      accept;
   logic                      stored;
   logic signed [SCORE_W-1:0] max_in;
   logic [CW-1:0]             count_in;
   logic signed [SCORE_W-1:0] bs_in [MAX_TOP];
   logic [AW-1:0]             bi_in [MAX_TOP];
   logic [MAX_TOP-1:0]        bv_in;
   logic [MAX_TOP-1:0]        ge;
   logic [KW-1:0]             kcap;
   logic [KW-1:0]             k_in;

   assign req_stall = job_valid_ff || store_busy;
   assign accept    = req_valid && !req_stall;
   assign stored    = (int'(count_ff) < MAX_SCORES);
   assign count_in  = stored ? count_ff + CW'(1) : count_ff;
   assign max_in    = (stored && (req_score > max_ff)) ? req_score : max_ff;

   // The kept list is sorted, so the "stays ahead" flags form a prefix and the
   // new score lands right after the last of them; later entries move down.
   always_comb begin
      for (int j = 0; j < MAX_TOP; j++) begin
         ge[j] = bv_ff[j] && (bs_ff[j] >= req_score);
      end
      for (int j = 0; j < MAX_TOP; j++) begin
         if (!stored || ge[j]) begin
            bs_in[j] = bs_ff[j];
            bi_in[j] = bi_ff[j];
            bv_in[j] = bv_ff[j];
         end else if (j == 0 || ge[(j == 0) ? 0 : j - 1]) begin
            bs_in[j] = req_score;
            bi_in[j] = count_ff[AW-1:0];
            bv_in[j] = 1'b1;
         end else begin
            bs_in[j] = bs_ff[(j == 0) ? 0 : j - 1];
            bi_in[j] = bi_ff[(j == 0) ? 0 : j - 1];
            bv_in[j] = bv_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   always_comb begin
      kcap = (int'(top_count) > MAX_TOP) ? KW'(MAX_TOP) : KW'(top_count);
      k_in = (int'(kcap) > int'(count_in)) ? KW'(count_in) : kcap;
   end

   always_ff @(posedge clock) begin
      if (accept && stored) begin
         store_mem[count_ff[AW-1:0]] <= req_score;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_ff       <= {1'b1, {(SCORE_W-1){1'b0}}};
         ovf_ff       <= 1'b0;
         bv_ff        <= '0;
         job_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_TOP; j++) begin
            bs_ff[j] <= {1'b1, {(SCORE_W-1){1'b0}}};
            bi_ff[j] <= '0;
         end
      end else begin
         if (job_take) begin
            job_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (req_last_score) begin
               job_valid_ff          <= 1'b1;
               job_info_ff.max_score <= max_in;
               job_info_ff.overflow  <= ovf_ff || !stored;
               job_count_ff          <= count_in;
               job_k_ff              <= k_in;
               for (int j = 0; j < MAX_TOP; j++) begin
                  job_scores_ff[j]  <= bs_in[j];
                  job_indices_ff[j] <= bi_in[j];
                  bs_ff[j]          <= {1'b1, {(SCORE_W-1){1'b0}}};
                  bi_ff[j]          <= '0;
               end
               count_ff <= '0;
               max_ff   <= {1'b1, {(SCORE_W-1){1'b0}}};
               ovf_ff   <= 1'b0;
               bv_ff    <= '0;
            end else begin
               count_ff <= count_in;
               max_ff   <= max_in;
               ovf_ff   <= ovf_ff || !stored;
               bv_ff    <= bv_in;
               for (int j = 0; j < MAX_TOP; j++) begin
                  bs_ff[j] <= bs_in[j];
                  bi_ff[j] <= bi_in[j];
               end
            end
         end
      end
   end

   assign job_valid   = job_valid_ff;
   assign job_info    = job_info_ff;
   assign job_count   = job_count_ff;
   assign job_k       = job_k_ff;
   assign job_scores  = job_scores_ff;
   assign job_indices = job_indices_ff;
   assign rd_data     = rd_data_ff;

endmodule

/* rtl/tsel_exp.sv */
module tsel_exp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [15:0]                  in_diff,
   output logic                         out_valid,
   output logic [tsel_pkg::EXP_W-1:0]   out_value
);
   import tsel_pkg::*;

   logic [2:0]          v_ff;
   logic [32:0]         m1_ff;
   logic [32:0]         m2_ff;
   logic [3:0]          lo1_ff;
   logic [1:0]          zero_ff;
   logic [EXP_W-1:0]    val_ff;
   logic [32:0]         m1_in;
   logic [32:0]         r1_full;
   logic [32:0]         r2_full;

   assign m1_in   = 33'(e_int(in_diff[12:8])) * 33'(e_hi(in_diff[7:4]));
   assign r1_full = (m1_ff + 33'd32768) >> 16;
   assign r2_full = (m2_ff + 33'd32768) >> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      m1_ff      <= m1_in;
      lo1_ff     <= in_diff[3:0];
      zero_ff[0] <= (in_diff > EXP_RANGE);
      m2_ff      <= 33'(r1_full[EXP_W-1:0]) * 33'(e_lo(lo1_ff));
      zero_ff[1] <= zero_ff[0];
      val_ff     <= zero_ff[1] ? '0 : r2_full[EXP_W-1:0];
   end

   assign out_valid = v_ff[2];
   assign out_value = val_ff;

endmodule

/* rtl/tsel_back.sv */
module tsel_back #(
   parameter int MAX_SCORES = 1024,
   parameter int MAX_TOP    = 8,
   parameter int AW         = $clog2(MAX_SCORES),
   parameter int CW         = $clog2(MAX_SCORES + 1),
   parameter int KW         = $clog2(MAX_TOP + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 job_valid,
   output logic                                 job_take,
   input  tsel_pkg::job_info_type               job_info,
   input  logic [CW-1:0]                        job_count,
   input  logic [KW-1:0]                        job_k,
   input  logic signed [tsel_pkg::SCORE_W-1:0]  job_scores [MAX_TOP],
   input  logic [AW-1:0]                        job_indices [MAX_TOP],
   output logic                                 store_busy,
   output logic [AW-1:0]                        rd_addr,
   input  logic signed [tsel_pkg::SCORE_W-1:0]  rd_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tsel_pkg::INDEX_W-1:0]         rsp_class_index,
   output logic signed [tsel_pkg::SCORE_W-1:0]  rsp_class_score,
   output logic [tsel_pkg::PROB_W-1:0]          rsp_probability,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last_result
);
   import tsel_pkg::*;
   `include "assert_macros.svh"

   localparam int TW  = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
   localparam int NW  = 33;
   localparam int RW  = SUM_W + 1;

   back_state_type state_ff, state_in;

   logic [CW-1:0]             n_ff;
   logic [KW-1:0]             k_ff;
   logic signed [SCORE_W-1:0] max_ff;
   logic                      ovf_ff;
   logic signed [SCORE_W-1:0] bs_ff [MAX_TOP];
   logic [AW-1:0]             bi_ff [MAX_TOP];
   logic [CW-1:0]             addr_ff;
   logic                      rdv_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic [1:0]                cnt_ff;
   logic [TW-1:0]             item_ff;
   logic [NW-1:0]             num_ff;
   logic [RW-1:0]             rem_ff;
   logic [NW-1:0]             quo_ff;
   logic [5:0]                dcnt_ff;

   logic                      rsp_valid_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic [PROB_W-1:0]         rsp_prob_ff;
   logic                      rsp_ovf_ff;
   logic                      rsp_last_ff;

   logic                      rd_issue;
   logic                      exp_issue;
   logic                      rsp_load;
   logic                      last_item;
   logic                      exp_in_valid;
   logic [15:0]               exp_diff;
   logic                      exp_out_valid;
   logic [EXP_W-1:0]          exp_value;
   logic signed [SCORE_W:0]   diff_store;
   logic signed [SCORE_W:0]   diff_best;
   logic [SUM_W:0]            sum_wide;
   logic [RW-1:0]             rem_sh;
   logic [PROB_W-1:0]         prob;

   assign last_item  = ((KW+1)'(item_ff) + (KW+1)'(1)) == (KW+1)'(k_ff);
   assign diff_store = max_ff - rd_data;
   assign diff_best  = max_ff - bs_ff[item_ff];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (job_valid) state_in = B_SUM;
         B_SUM:   if (addr_ff == n_ff - CW'(1)) state_in = B_DRAIN;
         B_DRAIN: if (cnt_ff == 2'd0) state_in = (k_ff == '0) ? B_IDLE : B_EXP;
         B_EXP:   if (cnt_ff == 2'd0) state_in = B_DIV;
         B_DIV:   if (dcnt_ff == 6'd1) state_in = B_OUT;
         B_OUT:   if (!rsp_valid_ff || !rsp_stall) state_in = last_item ? B_IDLE : B_EXP;
         default: state_in = B_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      job_take   = 1'b0;
      rd_issue   = 1'b0;
      exp_issue  = 1'b0;
      rsp_load   = 1'b0;
      store_busy = 1'b0;
      unique case (state_ff)
         B_IDLE:  job_take = job_valid;
         B_SUM: begin
            rd_issue   = 1'b1;
            store_busy = 1'b1;
         end
         B_DRAIN: store_busy = 1'b1;
         B_EXP:   exp_issue = (cnt_ff == 2'd3);
         B_DIV:   ;
         B_OUT:   rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign rd_addr      = addr_ff[AW-1:0];
   assign exp_in_valid = rdv_ff || exp_issue;
   assign exp_diff     = exp_issue ? diff_best[15:0] : diff_store[15:0];
   assign sum_wide     = {1'b0, sum_ff} + (SUM_W+1)'(exp_value);
   assign rem_sh       = {rem_ff[RW-2:0], num_ff[NW-1]};
   assign prob         = (sum_ff == '0) ? '0 :
                         (quo_ff > NW'(PROB_MAX)) ? PROB_MAX : quo_ff[PROB_W-1:0];

   tsel_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exp_in_valid),
      .in_diff   (exp_diff),
      .out_valid (exp_out_valid),
      .out_value (exp_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= rd_issue;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         n_ff    <= job_count;
         k_ff    <= job_k;
         max_ff  <= job_info.max_score;
         ovf_ff  <= job_info.overflow;
         bs_ff   <= job_scores;
         bi_ff   <= job_indices;
         addr_ff <= '0;
         sum_ff  <= '0;
      end
      if (rd_issue) begin
         addr_ff <= addr_ff + CW'(1);
      end
      if (exp_out_valid && (state_ff == B_SUM || state_ff == B_DRAIN)) begin
         sum_ff <= (sum_wide > (SUM_W+1)'(SUM_LIMIT)) ? SUM_LIMIT : sum_wide[SUM_W-1:0];
      end
      // The pipeline drains the memory read register and three exponent stages.
      if (state_ff == B_SUM && state_in == B_DRAIN) begin
         cnt_ff <= 2'd3;
      end else if (state_ff == B_DRAIN && state_in == B_EXP) begin
         cnt_ff  <= 2'd3;
         item_ff <= '0;
      end else if (state_ff == B_OUT && state_in == B_EXP) begin
         cnt_ff  <= 2'd3;
         item_ff <= item_ff + TW'(1);
      end else if (state_ff == B_DRAIN || state_ff == B_EXP) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
      if (state_ff == B_EXP && cnt_ff == 2'd0) begin
         num_ff  <= {exp_value, 16'b0} + NW'(sum_ff >> 1);
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= 6'(NW);
      end else if (state_ff == B_DIV) begin
         num_ff  <= {num_ff[NW-2:0], 1'b0};
         dcnt_ff <= dcnt_ff - 6'd1;
         if (rem_sh >= {1'b0, sum_ff}) begin
            rem_ff <= rem_sh - {1'b0, sum_ff};
            quo_ff <= {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[NW-2:0], 1'b0};
         end
      end
      if (rsp_load) begin
         rsp_index_ff <= INDEX_W'(bi_ff[item_ff]);
         rsp_score_ff <= bs_ff[item_ff];
         rsp_prob_ff  <= prob;
         rsp_ovf_ff   <= ovf_ff;
         rsp_last_ff  <= last_item;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_index_ff;
   assign rsp_class_score = rsp_score_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_result = rsp_last_ff;

   // The maximum score always adds a full unit, so the divisor is never zero.
   `TSEL_ASSERT(a_sum_nonzero, clock, reset, state_ff == B_DIV, sum_ff != '0)
   `TSEL_ASSERT(a_no_job_in_sum, clock, reset, state_ff == B_SUM, !job_valid)
   `TSEL_ASSERT_NEXT(a_exp_in_phase, clock, reset, state_ff == B_EXP && cnt_ff == 2'd1,
                     exp_out_valid)

endmodule

/* verif/tb_topk_softmax_selector_unit.sv */
module tb_topk_softmax_selector_unit;
   import tsel_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int RANK_DEPTH  = 8;
   localparam int DRAIN_WAIT  = 3000;
   localparam int CYCLE_LIMIT = 600000;

   localparam int unsigned EXP_WHOLE[17] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
      22, 8, 3, 1, 0, 0, 0, 0, 0};
   localparam int unsigned EXP_SIXTEENTH[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
      45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
   localparam int unsigned EXP_FINE[16] = '{65536, 65280, 65026, 64772, 64520, 64268,
      64018, 63768, 63520, 63272, 63025, 62780, 62535, 62291, 62049, 61806};

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic                      last;
   } score_item_type;

   typedef struct {
      logic [INDEX_W-1:0]        index;
      logic signed [SCORE_W-1:0] score;
      logic [PROB_W-1:0]         prob;
      logic                      ovf;
      logic                      last;
   } class_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [SCORE_W-1:0] req_score;
   logic                      req_last_score;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [INDEX_W-1:0]        rsp_class_index;
   logic signed [SCORE_W-1:0] rsp_class_score;
   logic [PROB_W-1:0]         rsp_probability;
   logic                      rsp_overflow;
   logic                      rsp_last_result;
   logic                      csr_write_enable;
   logic [TOP_W-1:0]          csr_write_data;

   score_item_type   score_q[$];
   class_result_type result_q[$];
   int               fail_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   bit               req_taken = 0;

   // Predictor state.
   logic [TOP_W-1:0]          top_count_copy;
   logic signed [SCORE_W-1:0] vec_store[STORE_DEPTH];
   int                        vec_len;
   logic signed [SCORE_W-1:0] vec_max;
   int                        rank_index[RANK_DEPTH];
   logic signed [SCORE_W-1:0] rank_score[RANK_DEPTH];
   bit                        rank_used[RANK_DEPTH];
   bit                        vec_overflow;

   topk_softmax_selector_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_score(req_score), .req_last_score(req_last_score),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_class_index(rsp_class_index), .rsp_class_score(rsp_class_score),
      .rsp_probability(rsp_probability), .rsp_overflow(rsp_overflow),
      .rsp_last_result(rsp_last_result),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned exp_of_gap(int unsigned d);
      longint unsigned r;
      if (d > 4096) return 0;
      r = EXP_WHOLE[d >> 8];
      r = (r * EXP_SIXTEENTH[(d >> 4) & 15] + 32768) >> 16;
      r = (r * EXP_FINE[d & 15] + 32768) >> 16;
      return r;
   endfunction

   function automatic void clear_vector();
      vec_len = 0;
      vec_max = -32768;
      vec_overflow = 0;
      for (int i = 0; i < RANK_DEPTH; i++) begin
         rank_index[i] = 0;
         rank_score[i] = -32768;
         rank_used[i] = 0;
      end
   endfunction

   function automatic void rank_score_in(int idx, logic signed [SCORE_W-1:0] s);
      int p;
      p = 0;
      while (p < RANK_DEPTH && rank_used[p] && rank_score[p] >= s) p++;
      if (p >= RANK_DEPTH) return;
      for (int j = RANK_DEPTH - 1; j > p; j--) begin
         rank_index[j] = rank_index[j-1];
         rank_score[j] = rank_score[j-1];
         rank_used[j] = rank_used[j-1];
      end
      rank_index[p] = idx;
      rank_score[p] = s;
      rank_used[p] = 1;
   endfunction

   function automatic void predict_topk(logic signed [SCORE_W-1:0] s, logic last);
      longint unsigned sum;
      longint unsigned e;
      longint unsigned p;
      int k;
      class_result_type r;
      if (vec_len < STORE_DEPTH) begin
         vec_store[vec_len] = s;
         if (s > vec_max) vec_max = s;
         rank_score_in(vec_len, s);
         vec_len++;
      end else begin
         vec_overflow = 1;
      end
      if (!last) return;
      sum = 0;
      for (int i = 0; i < vec_len; i++) begin
         sum += exp_of_gap(int'(vec_max) - int'(vec_store[i]));
         if (sum > SUM_LIMIT) sum = SUM_LIMIT;
      end
      k = top_count_copy;
      if (k > RANK_DEPTH) k = RANK_DEPTH;
      if (k > vec_len) k = vec_len;
      for (int i = 0; i < k; i++) begin
         e = exp_of_gap(int'(vec_max) - int'(rank_score[i]));
         p = 0;
         if (sum != 0) begin
            p = ((e << 16) + (sum >> 1)) / sum;
            if (p > 65535) p = 65535;
         end
         r.index = INDEX_W'(rank_index[i]);
         r.score = rank_score[i];
         r.prob = PROB_W'(p);
         r.ovf = vec_overflow;
         r.last = (i + 1 == k);
         result_q = {result_q, r};
      end
      clear_vector();
   endfunction

   task automatic push_score(logic signed [SCORE_W-1:0] s, logic last);
      score_item_type it;
      it.score = s;
      it.last = last;
      score_q = {score_q, it};
   endtask

   // Random vector; most scores sit close together so the probabilities spread out.
   task automatic push_random_vector(int len);
      logic signed [SCORE_W-1:0] base;
      logic signed [SCORE_W-1:0] s;
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(3) == 0) s = 16'($urandom);
         else if ($urandom_range(4) == 0) s = base;
         else s = base + $signed(16'($urandom_range(2048))) - 16'sd1024;
         push_score(s, i == len - 1);
      end
   endtask

   task automatic wait_idle_then_write(logic [TOP_W-1:0] value);
      while (score_q.size() != 0 || req_valid || result_q.size() != 0) @(posedge clock);
      // A vector may still be in flight when it produces no results.
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      csr_write_enable = 1;
      csr_write_data = value;
      top_count_copy = value;
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   // Request side driver; it also drives the response stall.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (score_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_score <= score_q[0].score;
            req_last_score <= score_q[0].last;
            req_valid <= 1;
            void'(score_q.pop_front());
         end else begin
            req_valid <= 0;
         end
      end
      if (!reset) rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      req_taken = 0;
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1;
         predict_topk(req_score, req_last_score);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            $error("unexpected result: index %0d score %0d", rsp_class_index,
               rsp_class_score);
            fail_count++;
         end else begin
            if (rsp_class_index !== result_q[0].index) begin
               $error("class_index: expected %0d, got %0d", result_q[0].index,
                  rsp_class_index);
               fail_count++;
            end
            if (rsp_class_score !== result_q[0].score) begin
               $error("class_score: expected %0d, got %0d", result_q[0].score,
                  rsp_class_score);
               fail_count++;
            end
            if (rsp_probability !== result_q[0].prob) begin
               $error("probability: expected %0d, got %0d", result_q[0].prob,
                  rsp_probability);
               fail_count++;
            end
            if (rsp_overflow !== result_q[0].ovf) begin
               $error("overflow: expected %0d, got %0d", result_q[0].ovf, rsp_overflow);
               fail_count++;
            end
            if (rsp_last_result !== result_q[0].last) begin
               $error("last_result: expected %0d, got %0d", result_q[0].last,
                  rsp_last_result);
               fail_count++;
            end
            void'(result_q.pop_front());
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [TOP_W-1:0] counts[8];
      counts = '{8, 0, 15, 1, 3, 9, 8, 2};
      reset = 1;
      req_valid = 0;
      req_score = 0;
      req_last_score = 0;
      rsp_stall = 0;
      csr_write_enable = 0;
      csr_write_data = 0;
      top_count_copy = 5;
      clear_vector();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: extremes, ties (lower index wins), and exponent cutoff at -16.
      push_score(16'sh7fff, 0);
      push_score(-16'sh8000, 0);
      push_score(16'sh0000, 0);
      push_score(16'sh7fff, 0);
      push_score(16'sh6fff, 0);
      push_score(16'sh6ffe, 0);
      push_score(16'sh0001, 1);
      push_score(-16'sh0100, 1);
      push_score(16'sh1000, 0);
      push_score(16'sh1000, 0);
      push_score(16'sh0000, 0);
      push_score(-16'sh0001, 0);
      push_score(16'shffff, 0);
      push_score(16'sh0fff, 1);
      push_score(-16'sh8000, 0);
      push_score(-16'sh8000, 1);

      for (int ph = 0; ph < 8; ph++) begin
         wait_idle_then_write(counts[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 69; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 69; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         for (int n = 0; n < 10; ) begin
            int len;
            len = $urandom_range(1, 10);
            push_random_vector(len);
            n += len;
         end
      end

      while (score_q.size() != 0 || req_valid || result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
